/* rtl/core/rsm_pkg.sv */
// shared types, constants and tables for the row softmax unit
`timescale 1ns / 1ps
package rsm_pkg;

    localparam int RSM_MAX_ROW = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_LOG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd1;

    localparam logic [6:0] ROW_LENGTH_RST = 7'd64;

    localparam logic [32:0] LOG2E_Q16 = 33'd94548;
    localparam logic [34:0] LN2_Q16   = 35'd45426;
    localparam int          EXP_STEPS = 6;
    localparam int          LN_STEPS  = 16;

    localparam logic signed [24:0] RES_MAX = 25'sd16777215;
    localparam logic signed [24:0] RES_MIN = -25'sd16777216;
    localparam logic [22:0]        SUM_MAX = 23'h7FFFFF;

    typedef struct packed {
        logic load;
        logic sum_clr;
        logic idx_clr;
        logic idx_inc;
        logic exp_start;
        logic acc;
        logic ln_start;
        logic div_start;
        logic emit;
        logic row_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic row_end;
        logic idx_last;
        logic exp_done;
        logic ln_done;
        logic div_done;
        logic mode;
    } t_dp_sts;

    // horner coefficients of 2^-f, innermost first after the seed
    function automatic logic [16:0] exp_coef(input logic [2:0] step);
        logic [16:0] c;
        unique case (step)
            3'd0:    c = 17'd87;
            3'd1:    c = 17'd630;
            3'd2:    c = 17'd3638;
            3'd3:    c = 17'd15743;
            3'd4:    c = 17'd45426;
            3'd5:    c = 17'd65536;
            default: c = 17'd0;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/rsm_exp.sv */
// iterative exp(-t/256) unit, one horner step per cycle
`timescale 1ns / 1ps
module rsm_exp
    import rsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_t,
    output logic        o_done,
    output logic [16:0] o_value
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [2:0]  r_step, n_step;
    logic [24:0] r_y, n_y;
    logic [16:0] r_p, n_p;
    logic [16:0] r_value, n_value;

    logic [32:0] w_yprod;
    logic [32:0] w_yrnd;
    logic [8:0]  w_k;
    logic [15:0] w_f;
    logic [32:0] w_pf;
    logic [16:0] w_rnd;
    logic [17:0] w_pn;
    logic [16:0] w_sh;
    logic [17:0] w_shr;

    assign w_yprod = 33'(i_t) * LOG2E_Q16;
    assign w_yrnd  = (w_yprod + 33'd128) >> 8;
    assign w_k     = r_y[24:16];
    assign w_f     = r_y[15:0];
    assign w_pf    = 33'(r_p) * 33'(w_f);
    assign w_rnd   = w_pf[32:16] + 17'(w_pf[15]);
    assign w_pn    = 18'(exp_coef(r_step)) - 18'(w_rnd);
    assign w_sh    = r_p >> (w_k - 9'd1);
    assign w_shr   = (18'(w_sh) + 18'd1) >> 1;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_step  = r_step;
        n_y     = r_y;
        n_p     = r_p;
        n_value = r_value;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = 3'd0;
            n_y    = w_yrnd[24:0];
            n_p    = 17'd10;
        end else if (r_busy) begin
            if (w_k >= 9'd18) begin
                n_value = 17'd0;
                n_done  = 1'b1;
                n_busy  = 1'b0;
            end else if (r_step < 3'(EXP_STEPS)) begin
                n_p    = w_pn[16:0];
                n_step = r_step + 3'd1;
            end else begin
                n_value = (w_k == 9'd0) ? r_p : w_shr[16:0];
                n_done  = 1'b1;
                n_busy  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step  <= n_step;
        r_y     <= n_y;
        r_p     <= n_p;
        r_value <= n_value;
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

/* rtl/core/rsm_ln.sv */
// iterative natural log unit, one squaring step per cycle
`timescale 1ns / 1ps
module rsm_ln
    import rsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [22:0] i_sum,
    output logic        o_done,
    output logic [18:0] o_ln
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_step, n_step;
    logic [2:0]  r_e, n_e;
    logic        r_zero, n_zero;
    logic [16:0] r_m, n_m;
    logic [15:0] r_frac, n_frac;
    logic [18:0] r_ln, n_ln;

    logic [2:0]  w_e;
    logic [22:0] w_norm;
    logic [33:0] w_sq;
    logic [17:0] w_m2;
    logic [34:0] w_lp;

    always_comb begin
        priority if (i_sum[22]) w_e = 3'd6;
        else if (i_sum[21])     w_e = 3'd5;
        else if (i_sum[20])     w_e = 3'd4;
        else if (i_sum[19])     w_e = 3'd3;
        else if (i_sum[18])     w_e = 3'd2;
        else if (i_sum[17])     w_e = 3'd1;
        else                    w_e = 3'd0;
    end

    assign w_norm = i_sum >> w_e;
    assign w_sq   = 34'(r_m) * 34'(r_m);
    assign w_m2   = w_sq[33:16];
    assign w_lp   = 35'({r_e, r_frac}) * LN2_Q16 + 35'd32768;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_e    = r_e;
        n_zero = r_zero;
        n_m    = r_m;
        n_frac = r_frac;
        n_ln   = r_ln;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = 5'd0;
            n_e    = w_e;
            n_zero = (i_sum[22:16] == 7'd0);
            n_m    = w_norm[16:0];
            n_frac = 16'd0;
        end else if (r_busy) begin
            if (r_step < 5'(LN_STEPS)) begin
                n_m    = w_m2[17] ? w_m2[17:1] : w_m2[16:0];
                n_frac = {r_frac[14:0], w_m2[17]};
                n_step = r_step + 5'd1;
            end else begin
                n_ln   = r_zero ? 19'd0 : w_lp[34:16];
                n_done = 1'b1;
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_e    <= n_e;
        r_zero <= n_zero;
        r_m    <= n_m;
        r_frac <= n_frac;
        r_ln   <= n_ln;
    end

    assign o_done = r_done;
    assign o_ln   = r_ln;

endmodule

/* rtl/core/rsm_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rsm_div
    import rsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_num,
    input  logic [22:0] i_den,
    output logic        o_done,
    output logic [32:0] o_quot
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [32:0] r_q, n_q;
    logic [22:0] r_rem, n_rem;
    logic [22:0] r_den, n_den;

    logic [23:0] w_rem2;
    logic        w_ge;

    assign w_rem2 = {r_rem, r_q[32]};
    assign w_ge   = (w_rem2 >= 24'(r_den));

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_q    = i_num;
            n_rem  = 23'd0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = w_ge ? 23'(w_rem2 - 24'(r_den)) : w_rem2[22:0];
            n_q   = {r_q[31:0], w_ge};
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd32) begin
                if (r_den == 23'd0) begin
                    n_q = 33'd0;
                end
                n_done = 1'b1;
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* rtl/core/rsm_datapath.sv */
// row buffer, running max, exp sum, arithmetic units and result register
`timescale 1ns / 1ps
module rsm_datapath
    import rsm_pkg::*;
#(
    parameter int MAX_ROW = RSM_MAX_ROW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic signed [15:0]    i_element_value,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_result_valid,
    output logic signed [24:0]    o_result_value,
    output logic                  o_last_of_row
);

    localparam int AW = $clog2(MAX_ROW);
    localparam int CW = $clog2(MAX_ROW + 1);
    localparam int LW = (CW > 7) ? CW : 7;
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_ROW);

    logic [15:0] mem_row [MAX_ROW];

    logic               r_log_mode;
    logic [6:0]         r_row_length;
    logic               r_mode;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_idx;
    logic signed [15:0] r_max;
    logic signed [15:0] r_rdata;
    logic [22:0]        r_sum;
    logic               r_out_valid;
    logic               r_out_last;
    logic signed [24:0] r_out_value;
    logic signed [24:0] n_out_value;

    logic [LW-1:0]      w_rl;
    logic [LW-1:0]      w_len;
    logic [LW-1:0]      w_cnt_inc;
    logic               w_idx_last;
    logic [16:0]        w_diff;
    logic [23:0]        w_sum_add;
    logic               w_exp_done;
    logic [16:0]        w_exp;
    logic               w_ln_done;
    logic [18:0]        w_ln;
    logic               w_div_done;
    logic [32:0]        w_quot;
    logic [32:0]        w_num;
    logic signed [26:0] w_log;

    assign w_rl      = LW'(r_row_length);
    assign w_len     = (w_rl == '0) ? LW'(1) : ((w_rl > MAX_LEN) ? MAX_LEN : w_rl);
    assign w_cnt_inc = LW'(r_count) + LW'(1);
    assign w_idx_last = ((LW'(r_idx) + LW'(1)) == LW'(r_count));
    assign w_diff    = 17'(r_max) - 17'(r_rdata);
    assign w_sum_add = 24'(r_sum) + 24'(w_exp);
    assign w_num     = {w_exp[16:0], 16'd0} + 33'(r_sum[22:1]);
    assign w_log     = ($signed(27'(signed'(w_diff))) * -27'sd256)
                       - $signed(27'(w_ln));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_mode   <= 1'b0;
            r_row_length <= ROW_LENGTH_RST;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_LOG_MODE) begin
                r_log_mode <= i_cfg_wdata[0];
            end else if (i_cfg_index == CFG_ROW_LENGTH) begin
                r_row_length <= i_cfg_wdata[6:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            mem_row[r_count[AW-1:0]] <= i_element_value;
        end
        r_rdata <= mem_row[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_max   <= 16'sh8000;
            r_idx   <= '0;
            r_sum   <= '0;
            r_mode  <= 1'b0;
        end else begin
            if (i_cmd.row_clr) begin
                r_count <= '0;
                r_max   <= 16'sh8000;
            end else if (i_cmd.load) begin
                r_count <= CW'(w_cnt_inc);
                if (i_element_value > r_max) begin
                    r_max <= i_element_value;
                end
                if (w_cnt_inc >= w_len) begin
                    r_mode <= r_log_mode;
                end
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + AW'(1);
            end
            if (i_cmd.sum_clr) begin
                r_sum <= '0;
            end else if (i_cmd.acc) begin
                r_sum <= w_sum_add[23] ? SUM_MAX : w_sum_add[22:0];
            end
        end
    end

    rsm_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.exp_start),
        .i_t     (w_diff[15:0]),
        .o_done  (w_exp_done),
        .o_value (w_exp)
    );

    rsm_ln u_ln (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.ln_start),
        .i_sum   (r_sum),
        .o_done  (w_ln_done),
        .o_ln    (w_ln)
    );

    rsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (r_sum),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        if (r_mode) begin
            if (w_log < 27'(RES_MIN)) begin
                n_out_value = RES_MIN;
            end else if (w_log > 27'(RES_MAX)) begin
                n_out_value = RES_MAX;
            end else begin
                n_out_value = w_log[24:0];
            end
        end else begin
            n_out_value = (w_quot > 33'(RES_MAX)) ? RES_MAX : w_quot[24:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
            r_out_last  <= i_cmd.emit & w_idx_last;
        end
        if (i_cmd.emit) begin
            r_out_value <= n_out_value;
        end
    end

    assign o_sts.row_end  = (w_cnt_inc >= w_len);
    assign o_sts.idx_last = w_idx_last;
    assign o_sts.exp_done = w_exp_done;
    assign o_sts.ln_done  = w_ln_done;
    assign o_sts.div_done = w_div_done;
    assign o_sts.mode     = r_mode;

    assign o_result_valid = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_last_of_row  = r_out_last;

endmodule

/* rtl/core/rsm_ctrl.sv */
// controller state machine: load, sum, log and emit passes
`timescale 1ns / 1ps
module rsm_ctrl
    import rsm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    typedef enum logic [9:0] {
        S_LOAD      = 10'b0000000001,
        S_SUM_RD    = 10'b0000000010,
        S_SUM_EXP   = 10'b0000000100,
        S_SUM_WAIT  = 10'b0000001000,
        S_LN_GO     = 10'b0000010000,
        S_LN_WAIT   = 10'b0000100000,
        S_EMIT_RD   = 10'b0001000000,
        S_EMIT_EXP  = 10'b0010000000,
        S_EMIT_WAIT = 10'b0100000000,
        S_DIV_WAIT  = 10'b1000000000
    } t_state;

    t_state  r_state, n_state;
    t_dp_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                if (i_start) begin
                    w_cmd.load = 1'b1;
                    if (i_sts.row_end) begin
                        w_cmd.sum_clr = 1'b1;
                        w_cmd.idx_clr = 1'b1;
                        n_state       = S_SUM_RD;
                    end
                end
            end
            S_SUM_RD: begin
                n_state = S_SUM_EXP;
            end
            S_SUM_EXP: begin
                w_cmd.exp_start = 1'b1;
                n_state         = S_SUM_WAIT;
            end
            S_SUM_WAIT: begin
                if (i_sts.exp_done) begin
                    w_cmd.acc = 1'b1;
                    if (i_sts.idx_last) begin
                        w_cmd.idx_clr = 1'b1;
                        n_state       = i_sts.mode ? S_LN_GO : S_EMIT_RD;
                    end else begin
                        w_cmd.idx_inc = 1'b1;
                        n_state       = S_SUM_RD;
                    end
                end
            end
            S_LN_GO: begin
                w_cmd.ln_start = 1'b1;
                n_state        = S_LN_WAIT;
            end
            S_LN_WAIT: begin
                if (i_sts.ln_done) begin
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_EXP;
            end
            S_EMIT_EXP: begin
                if (i_sts.mode) begin
                    w_cmd.emit = 1'b1;
                    if (i_sts.idx_last) begin
                        w_cmd.row_clr = 1'b1;
                        n_state       = S_LOAD;
                    end else begin
                        w_cmd.idx_inc = 1'b1;
                        n_state       = S_EMIT_RD;
                    end
                end else begin
                    w_cmd.exp_start = 1'b1;
                    n_state         = S_EMIT_WAIT;
                end
            end
            S_EMIT_WAIT: begin
                if (i_sts.exp_done) begin
                    w_cmd.div_start = 1'b1;
                    n_state         = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    w_cmd.emit = 1'b1;
                    if (i_sts.idx_last) begin
                        w_cmd.row_clr = 1'b1;
                        n_state       = S_LOAD;
                    end else begin
                        w_cmd.idx_inc = 1'b1;
                        n_state       = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = w_cmd;
    assign o_busy = (r_state != S_LOAD);

endmodule

/* rtl/core/row_softmax_unit.sv */
// top level of the row softmax / log-softmax unit
`timescale 1ns / 1ps
// Elements of a row are taken one per cycle while o_busy is low; the request
// that completes the row raises o_busy until every result of the row has been
// strobed out on o_result_valid, one cycle each, in arrival order, with
// o_last_of_row on the final one. The receiver cannot stall. Per element the
// sum pass runs a buffer read and the iterative exp unit; the emit pass runs
// the exp unit and then the bit-serial divider in softmax mode, and only a
// buffer read in log mode, which also runs the squaring ln unit once per
// row.
module row_softmax_unit
    import rsm_pkg::*;
#(
    parameter int MAX_ROW = RSM_MAX_ROW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic signed [15:0]    i_element_value,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                  o_result_valid,
    output logic signed [24:0]    o_result_value,
    output logic                  o_last_of_row
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    rsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    rsm_datapath #(
        .MAX_ROW (MAX_ROW)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_element_value (i_element_value),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_result_valid  (o_result_valid),
        .o_result_value  (o_result_value),
        .o_last_of_row   (o_last_of_row)
    );

endmodule

/* rtl/core/rsm_checker.sv */
// port-level checker for the row softmax unit, bound to the top level
`timescale 1ns / 1ps
module rsm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_busy,
    input logic        o_result_valid,
    input logic        o_last_of_row
);

    a_last_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_of_row |-> o_result_valid)
        else $error("last flag without result");

    a_mid_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last_of_row) |-> o_busy)
        else $error("non-final result while idle");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last_of_row) |-> !o_busy)
        else $error("still busy after final result");

    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_busy && $past(!o_busy) && $past(i_rst_n)) |-> !o_result_valid)
        else $error("result while idle");

endmodule

bind row_softmax_unit rsm_checker u_rsm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_busy         (o_busy),
    .o_result_valid (o_result_valid),
    .o_last_of_row  (o_last_of_row)
);

/* bench/tb_row_softmax_unit.sv */
// self-checking testbench for the row softmax / log-softmax unit
`timescale 1ns / 1ps
module tb_row_softmax_unit;
    import rsm_pkg::*;

    localparam int ROW_CAP   = 64;
    localparam int IDLE_WAIT = 200;
    localparam int WDOG_MAX  = 20000;

    typedef struct {
        logic signed [24:0] value;
        logic               last;
    } t_softmax_out;

    class softmax_scoreboard;
        int                  errors;
        logic                mode_log;
        logic [6:0]          len_reg;
        logic signed [15:0]  row_buf [ROW_CAP];
        int                  loaded;
        logic signed [15:0]  row_peak;
        t_softmax_out        pending [$];

        function void reset_state();
            errors   = 0;
            mode_log = 1'b0;
            len_reg  = ROW_LENGTH_RST;
            loaded   = 0;
            row_peak = -16'sd32768;
            pending.delete();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_LOG_MODE) begin
                mode_log = val[0];
            end else if (idx == CFG_ROW_LENGTH) begin
                len_reg = val;
            end
        endfunction

        // exp(-t/256) in q16
        function automatic longint exp_neg(longint t);
            longint y, k, f, p;
            longint coef [6] = '{87, 630, 3638, 15743, 45426, 65536};
            y = (t * 94548 + 128) >>> 8;
            k = y >>> 16;
            f = y & 16'hFFFF;
            if (k >= 18) begin
                return 0;
            end
            p = 10;
            for (int i = 0; i < 6; i++) begin
                p = coef[i] - ((p * f + 32768) >>> 16);
            end
            if (k > 0) begin
                p = (p + (longint'(1) << (k - 1))) >>> k;
            end
            return p;
        endfunction

        function automatic longint ln_sum(longint s);
            int n;
            longint m, frac, l2;
            if (s < 65536) begin
                return 0;
            end
            n = 22;
            while (n > 16 && ((s >> n) & 1) == 0) begin
                n--;
            end
            m = (s << 16) >> n;
            frac = 0;
            for (int i = 0; i < 16; i++) begin
                m = (m * m) >> 16;
                if (m >= 131072) begin
                    m = m >> 1;
                    frac |= longint'(1) << (15 - i);
                end
            end
            l2 = (longint'(n - 16) << 16) | frac;
            return (l2 * 45426 + 32768) >> 16;
        endfunction

        function void note_request(logic signed [15:0] x);
            int len;
            longint sum, lnv, r, d, e;
            t_softmax_out o;
            len = (len_reg == 0) ? 1 : ((len_reg > ROW_CAP) ? ROW_CAP : len_reg);
            if (loaded >= ROW_CAP) begin
                loaded = ROW_CAP - 1;
            end
            row_buf[loaded] = x;
            if (x > row_peak) begin
                row_peak = x;
            end
            loaded++;
            if (loaded < len) begin
                return;
            end
            sum = 0;
            for (int i = 0; i < loaded; i++) begin
                sum += exp_neg(longint'(row_peak) - longint'(row_buf[i]));
                if (sum > 64'h7FFFFF) begin
                    sum = 64'h7FFFFF;
                end
            end
            lnv = mode_log ? ln_sum(sum) : 0;
            for (int i = 0; i < loaded; i++) begin
                d = longint'(row_buf[i]) - longint'(row_peak);
                if (mode_log) begin
                    r = d * 256 - lnv;
                end else if (sum == 0) begin
                    r = 0;
                end else begin
                    e = exp_neg(-d);
                    r = ((e << 16) + sum / 2) / sum;
                end
                if (r < -16777216) begin
                    r = -16777216;
                end
                if (r > 16777215) begin
                    r = 16777215;
                end
                o.value = r[24:0];
                o.last  = (i + 1 == loaded);
                pending.insert(pending.size(), o);
            end
            loaded   = 0;
            row_peak = -16'sd32768;
        endfunction

        function void check_result(logic signed [24:0] value, logic last);
            t_softmax_out o;
            if (pending.size() == 0) begin
                $error("unexpected result value=%0d last=%0b", value, last);
                errors++;
                return;
            end
            o = pending.pop_front();
            if (value !== o.value) begin
                $error("result_value expected %0d actual %0d", o.value, value);
                errors++;
            end
            if (last !== o.last) begin
                $error("last_of_row expected %0b actual %0b", o.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic signed [15:0]    element_value;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  result_valid;
    logic signed [24:0]    result_value;
    logic                  last_of_row;

    softmax_scoreboard sb;
    int                idle_cycles;
    logic              timed_out;

    row_softmax_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_element_value (element_value),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .o_result_valid  (result_valid),
        .o_result_value  (result_value),
        .o_last_of_row   (last_of_row)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // sample at the rising edge; watchdog counts cycles with no traffic
    always @(posedge clk) begin
        if (rst_n) begin
            if (result_valid) begin
                sb.check_result(result_value, last_of_row);
            end
            if ((start && !busy) || result_valid) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    always @(posedge clk) begin
        if (idle_cycles >= WDOG_MAX && !timed_out) begin
            timed_out = 1'b1;
            $display("tb_row_softmax_unit: FAIL");
            $finish;
        end
    end

    task automatic send_request(logic signed [15:0] x);
        element_value <= x;
        start         <= 1'b1;
        do @(posedge clk); while (busy);
        sb.note_request(x);
        @(negedge clk);
    endtask

    task automatic drop_start(int gap);
        start <= 1'b0;
        repeat (gap) @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) begin
            @(negedge clk);
        end
        repeat (IDLE_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_rows(int count);
        int burst;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 2) == 0) begin
                    drop_start($urandom_range(1, 20));
                end
            end
            burst--;
            case ($urandom_range(0, 3))
                0: send_request(16'($urandom()));
                1: send_request(16'($urandom_range(0, 2047)) - 16'sd1024);
                2: send_request($urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000);
                default: send_request(16'sh0100 + 16'($urandom_range(0, 63)));
            endcase
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        timed_out     = 1'b0;
        idle_cycles   = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        element_value = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: length one, extremes, both modes
        write_reg(CFG_ROW_LENGTH, 7'd1);
        send_request(16'sh7FFF);
        send_request(-16'sh8000);
        drain();
        write_reg(CFG_ROW_LENGTH, 7'd0);
        send_request(16'sh0000);
        drain();
        write_reg(CFG_ROW_LENGTH, 7'd4);
        send_request(16'sh7FFF);
        send_request(-16'sh8000);
        send_request(16'sh7F00);
        send_request(16'sh7FFF);
        drain();
        write_reg(CFG_LOG_MODE, 7'd1);
        send_request(16'sh0000);
        send_request(16'sh0000);
        send_request(-16'sh8000);
        send_request(16'sh7FFF);
        drain();
        write_reg(CFG_ROW_LENGTH, 7'd127);
        write_reg(CFG_LOG_MODE, 7'd0);
        for (int i = 0; i < 5; i++) begin
            send_request(16'sh0200 - 16'(i));
        end
        // shorten mid-row: the row closes on the next element
        drain();
        write_reg(CFG_ROW_LENGTH, 7'd3);
        send_request(16'sh0010);
        drain();
        write_reg(CFG_ROW_LENGTH, 7'd64);
        write_reg(CFG_LOG_MODE, 7'd1);
        for (int i = 0; i < 64; i++) begin
            send_request(16'($urandom()));
        end
        drain();

        // random phases with small rows
        write_reg(CFG_LOG_MODE, 7'd0);
        write_reg(CFG_ROW_LENGTH, 7'd5);
        random_rows(15);
        drain();
        write_reg(CFG_LOG_MODE, 7'd1);
        write_reg(CFG_ROW_LENGTH, 7'd7);
        random_rows(20);
        drain();
        write_reg(CFG_LOG_MODE, 7'd0);
        write_reg(CFG_ROW_LENGTH, 7'd2);
        random_rows(14);
        drain();

        if (sb.errors == 0) begin
            $display("tb_row_softmax_unit: PASS");
        end else begin
            $display("tb_row_softmax_unit: FAIL");
        end
        $finish;
    end

endmodule
